// File: design/utf8v_pkg.sv
// Shared types, codes and the code point check for the UTF-8 stream validator.
// Depends on nothing; utf8v_step and utf8_stream_validator import it.
package utf8v_pkg;

    // Open sequence kind, named by its total byte count
    typedef logic [1:0] t_seq;
    localparam t_seq SEQ_NONE  = 2'd0;
    localparam t_seq SEQ_TWO   = 2'd1;
    localparam t_seq SEQ_THREE = 2'd2;
    localparam t_seq SEQ_FOUR  = 2'd3;

    typedef logic [1:0]  t_cont;
    typedef logic [20:0] t_code;

    localparam t_code CODE_MIN_THREE = 21'h000800;
    localparam t_code CODE_MIN_FOUR  = 21'h010000;
    localparam t_code CODE_LIMIT     = 21'h110000;
    localparam t_code NONCHAR_LO     = 21'h00FDD0;
    localparam t_code NONCHAR_HI     = 21'h00FDEF;
    localparam logic [9:0] SURROGATE_TOP = 10'b0000011011;

    // Verdict flags from the step logic to the result register
    typedef struct packed {
        logic emit;
        logic ok;
    } t_verdict;

    // Accept a finished three- or four-byte code point
    function automatic logic code_ok(input t_code v, input t_seq seq);
        logic pass;
        pass = 1'b1;
        if (seq == SEQ_FOUR) begin
            if (v < CODE_MIN_FOUR) pass = 1'b0;
        end else begin
            if (v < CODE_MIN_THREE) pass = 1'b0;
        end
        if (v >= CODE_LIMIT) pass = 1'b0;
        if (v[20:11] == SURROGATE_TOP) pass = 1'b0;
        if (v >= NONCHAR_LO && v <= NONCHAR_HI) pass = 1'b0;
        if (&v[15:1]) pass = 1'b0;
        return pass;
    endfunction

endpackage

// File: design/utf8v_byte_if.sv
// Input channel of the UTF-8 stream validator: one string byte per word.
// Depends on nothing.
interface utf8v_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, output data_byte, output is_last, input ready);
    modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

// File: design/utf8v_res_if.sv
// Result channel of the UTF-8 stream validator: one verdict per word.
// Depends on nothing; the offset width is a parameter.
interface utf8v_res_if #(
    parameter int OFFSET_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic                   valid_res;
    logic [OFFSET_BITS-1:0] end_offset;

    modport source (output valid, output valid_res, output end_offset, input ready);
    modport sink   (input valid, input valid_res, input end_offset, output ready);
endinterface

// File: design/utf8v_step.sv
// Per-byte decode state and next-state logic of the UTF-8 stream validator.
// Depends on utf8v_pkg.
module utf8v_step
    import utf8v_pkg::*;
#(
    parameter int OFFSET_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic [7:0]             i_byte,
    input  logic                   i_last,
    output t_verdict               o_verdict,
    output logic [OFFSET_BITS-1:0] o_off
);

    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_lead, n_lead;
    t_cont                  r_cont, n_cont;
    t_code                  r_code, n_code;
    t_seq                   r_seq, n_seq;
    logic                   r_skip, n_skip;

    always_comb begin
        logic [OFFSET_BITS-1:0] nxt;
        logic                   give;
        logic                   lead2;
        logic                   lead3;
        logic                   lead4;
        t_code                  code_new;
        t_cont                  cont_new;

        nxt      = r_pos + 1'b1;
        give     = 1'b0;
        lead2    = (i_byte[7:5] == 3'b110);
        lead3    = (i_byte[7:4] == 4'b1110);
        lead4    = (i_byte[7:3] == 5'b11110);
        code_new = (r_seq != SEQ_TWO) ? {r_code[14:0], i_byte[5:0]} : r_code;
        cont_new = r_cont - 1'b1;

        n_pos  = r_pos;
        n_lead = r_lead;
        n_cont = r_cont;
        n_code = r_code;
        n_seq  = r_seq;
        n_skip = r_skip;
        o_verdict = '0;
        o_off     = r_pos;

        if (r_skip) begin
            // drop bytes up to the end of the buffer
            if (i_last) n_skip = 1'b0;
        end else if (r_cont == 2'd0) begin
            if (i_byte == 8'h00) begin
                give = 1'b1;
                o_verdict.ok = 1'b1;
            end else if (!i_byte[7]) begin
                if (i_last) begin
                    give = 1'b1;
                    o_verdict.ok = 1'b1;
                    o_off = nxt;
                end else begin
                    n_pos = nxt;
                end
            end else if ((lead2 && i_byte[4:1] != 4'd0) || lead3 || lead4) begin
                n_lead = r_pos;
                if (lead2) begin
                    n_seq  = SEQ_TWO;
                    n_cont = 2'd1;
                    n_code = '0;
                end else if (lead3) begin
                    n_seq  = SEQ_THREE;
                    n_cont = 2'd2;
                    n_code = {17'd0, i_byte[3:0]};
                end else begin
                    n_seq  = SEQ_FOUR;
                    n_cont = 2'd3;
                    n_code = {18'd0, i_byte[2:0]};
                end
                if (i_last) give = 1'b1;
                else        n_pos = nxt;
            end else begin
                // overlong two-byte lead or stray byte
                give = 1'b1;
            end
        end else begin
            o_off = r_lead;
            if (i_byte[7:6] != 2'b10) begin
                give = 1'b1;
            end else if (cont_new == 2'd0) begin
                if (r_seq != SEQ_TWO && !code_ok(code_new, r_seq)) begin
                    give = 1'b1;
                end else if (i_last) begin
                    give = 1'b1;
                    o_verdict.ok = 1'b1;
                    o_off = nxt;
                end else begin
                    n_cont = cont_new;
                    n_seq  = SEQ_NONE;
                    n_code = '0;
                    n_pos  = nxt;
                end
            end else if (i_last) begin
                give = 1'b1;
            end else begin
                n_cont = cont_new;
                n_code = code_new;
                n_pos  = nxt;
            end
        end

        if (give) begin
            o_verdict.emit = 1'b1;
            n_pos  = '0;
            n_lead = '0;
            n_cont = 2'd0;
            n_code = '0;
            n_seq  = SEQ_NONE;
            n_skip = !i_last;
        end
        if (r_skip && i_last) begin
            n_pos  = '0;
            n_lead = '0;
            n_cont = 2'd0;
            n_code = '0;
            n_seq  = SEQ_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_lead <= '0;
            r_cont <= 2'd0;
            r_code <= '0;
            r_seq  <= SEQ_NONE;
            r_skip <= 1'b0;
        end else if (i_fire) begin
            r_pos  <= n_pos;
            r_lead <= n_lead;
            r_cont <= n_cont;
            r_code <= n_code;
            r_seq  <= n_seq;
            r_skip <= n_skip;
        end
    end

    a_skip_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip |-> !o_verdict.emit)
        else $error("verdict while skipping");

    a_skip_after_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_verdict.emit && !i_last |=> r_skip)
        else $error("no skip after mid-buffer verdict");

    a_cont_seq_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cont == 2'd0) == (r_seq == SEQ_NONE))
        else $error("continuation count and sequence kind disagree");

    a_cont_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cont <= r_seq)
        else $error("more continuations left than the sequence holds");

endmodule

// File: design/utf8_stream_validator.sv
// Top level of the UTF-8 stream validator: input register, step logic, result register.
// Depends on utf8v_pkg, utf8v_byte_if, utf8v_res_if and utf8v_step.
//
// The block checks strings of UTF-8 bytes that arrive one byte per word on i_in, the last
// byte of each buffer flagged by is_last. A NUL byte in lead position also ends the string.
// For every string exactly one verdict word leaves on o_res: valid_res set with end_offset
// at the NUL offset or at the buffer's byte count when the string is good, valid_res clear
// with end_offset at the lead byte of the failing sequence otherwise. After a verdict, the
// remaining bytes up to and including the next is_last byte are dropped, and the byte after
// that starts a new string at offset 0. Rejected are stray continuation bytes, bytes F8..FF,
// overlong forms, surrogates, the noncharacters FDD0..FDEF and xFFFE/xFFFF, code points
// above 10FFFF, and a NUL or end of buffer inside a sequence. Offsets wrap at
// 2^OFFSET_BITS. Throughput is one byte per cycle unless the input is held; an accepted
// byte sits in the input register while the decode step works on it, and the result
// register loads its verdict when the step fires on that byte. The input register refills
// while a finished verdict waits in the result register, so only a full result register
// with o_res.ready low holds the input.
module utf8_stream_validator
    import utf8v_pkg::*;
#(
    parameter int OFFSET_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    utf8v_byte_if.sink    i_in,
    utf8v_res_if.source   o_res
);

    // input register
    logic       r_in_vld;
    logic [7:0] r_byte;
    logic       r_last;

    // result register
    logic                   r_out_vld;
    logic                   r_ok;
    logic [OFFSET_BITS-1:0] r_off;

    t_verdict               w_verdict;
    logic [OFFSET_BITS-1:0] w_off;
    logic                   w_fire;
    logic                   w_in_take;

    // Advance the held byte when the result register is free or drains this cycle
    assign w_fire    = r_in_vld && (!r_out_vld || o_res.ready);
    assign w_in_take = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_vld || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_byte <= i_in.data_byte;
            r_last <= i_in.is_last;
        end
    end

    utf8v_step #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_byte    (r_byte),
        .i_last    (r_last),
        .o_verdict (w_verdict),
        .o_off     (w_off)
    );

    // Load a verdict, drop the old one once taken, hold otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire && w_verdict.emit) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_verdict.emit) begin
            r_ok  <= w_verdict.ok;
            r_off <= w_off;
        end
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.valid_res  = r_ok;
    assign o_res.end_offset = r_off;

    a_fire_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |-> r_in_vld)
        else $error("step fired without a held byte");

    a_take_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> r_in_vld)
        else $error("accepted byte not held");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_res.ready |-> !w_fire)
        else $error("step advanced over a waiting verdict");

endmodule
